// File: sv/ccws_pkg.sv
// shared types, command codes, reset values and month length lookup
// for the calendar clock with stopwatch; no dependencies
package ccws_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_SET   = 2'd1,
    FUNC_START = 2'd2,
    FUNC_STOP  = 2'd3
  } func_t;

  // one input item as held in the input register
  typedef struct packed {
    func_t       func;
    logic [11:0] set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
  } ccws_item_t;

  // full clock and stopwatch state, also the result item
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [6:0]  centi;
    logic        chrono_on;
    logic [31:0] chrono_total;
  } ccws_state_t;

  localparam logic [6:0] CENTI_WRAP  = 7'd100;
  localparam logic [6:0] SEC_WRAP    = 7'd60;
  localparam logic [6:0] MIN_WRAP    = 7'd60;
  localparam logic [5:0] HOUR_WRAP   = 6'd24;
  localparam logic [4:0] MONTH_LAST  = 5'd12;
  localparam logic [4:0] DAYS_LEAP   = 5'd29;

  localparam logic [11:0] RST_YEAR   = 12'd2020;
  localparam logic [3:0]  RST_MONTH  = 4'd2;
  localparam logic [4:0]  RST_DAY    = 5'd28;
  localparam logic [4:0]  RST_HOUR   = 5'd23;
  localparam logic [5:0]  RST_MINUTE = 6'd59;
  localparam logic [5:0]  RST_SECOND = 6'd50;
  localparam logic [6:0]  RST_CENTI  = 7'd15;

  // days in a month; months outside 1..12 count as 31 days
  function automatic logic [4:0] days_in(logic [3:0] month, logic [11:0] year);
    logic [4:0] d;
    case (month)
      4'd2:    d = (year[1:0] == 2'b00) ? DAYS_LEAP : 5'd28;
      4'd4:    d = 5'd30;
      4'd6:    d = 5'd30;
      4'd9:    d = 5'd30;
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// File: sv/ccws_step.sv
// next clock and stopwatch state for one command: tick cascade, set, start, stop
// depends on ccws_pkg
module ccws_step (
  input  ccws_pkg::ccws_item_t  item,
  input  ccws_pkg::ccws_state_t cur,
  output ccws_pkg::ccws_state_t nxt
);
  import ccws_pkg::*;

  logic [6:0]  centi_inc;
  logic        c_carry;
  logic [6:0]  sec_v;
  logic        s_carry;
  logic [6:0]  min_v;
  logic        m_carry;
  logic [5:0]  hour_v;
  logic        h_carry;
  logic [5:0]  day_v;
  logic        d_carry;
  logic [4:0]  mon_v;
  logic        mo_carry;
  logic [4:0]  limit;
  ccws_state_t tick_st;

  // tick cascade; every stage checks its limit even without an incoming carry
  always_comb begin
    limit     = days_in(cur.month, cur.year);
    centi_inc = cur.centi + 7'd1;
    c_carry   = (centi_inc >= CENTI_WRAP);
    sec_v     = {1'b0, cur.second} + {6'd0, c_carry};
    s_carry   = (sec_v >= SEC_WRAP);
    min_v     = {1'b0, cur.minute} + {6'd0, s_carry};
    m_carry   = (min_v >= MIN_WRAP);
    hour_v    = {1'b0, cur.hour} + {5'd0, m_carry};
    h_carry   = (hour_v >= HOUR_WRAP);
    day_v     = {1'b0, cur.day} + {5'd0, h_carry};
    d_carry   = (day_v > {1'b0, limit});
    mon_v     = {1'b0, cur.month} + {4'd0, d_carry};
    mo_carry  = (mon_v > MONTH_LAST);

    tick_st        = cur;
    tick_st.centi  = c_carry  ? 7'd0 : centi_inc;
    tick_st.second = s_carry  ? 6'd0 : sec_v[5:0];
    tick_st.minute = m_carry  ? 6'd0 : min_v[5:0];
    tick_st.hour   = h_carry  ? 5'd0 : hour_v[4:0];
    tick_st.day    = d_carry  ? 5'd1 : day_v[4:0];
    tick_st.month  = mo_carry ? 4'd1 : mon_v[3:0];
    tick_st.year   = cur.year + {11'd0, mo_carry};
    if (c_carry && cur.chrono_on) begin
      tick_st.chrono_total = cur.chrono_total + 32'd1;
    end
  end

  always_comb begin
    nxt = cur;
    case (item.func)
      FUNC_TICK: begin
        nxt = tick_st;
      end
      FUNC_SET: begin
        nxt.year   = item.set_year;
        nxt.month  = item.set_month;
        nxt.day    = item.set_day;
        nxt.hour   = item.set_hour;
        nxt.minute = item.set_minute;
        nxt.second = item.set_second;
        nxt.centi  = 7'd0;
      end
      FUNC_START: begin
        nxt.chrono_on    = 1'b1;
        nxt.chrono_total = 32'd0;
      end
      default: begin
        nxt.chrono_on    = 1'b0;
        nxt.chrono_total = 32'd0;
      end
    endcase
  end

endmodule

// File: sv/calendar_clock_with_stopwatch.sv
// top level of the calendar clock with stopwatch: input register, state/result register
// depends on ccws_pkg and ccws_step
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------------------
//   in_     | into      | in_valid / in_stall | func, set_year .. set_second
//   out_    | out of    | out_valid/out_stall | year .. centisecond, chrono_running/_seconds
//
// one item per cycle sustained while out_stall stays low; an input transfer reaches the result
// through the input register, then one pass through the tick cascade into the state register
// the state register is the result register: its value after an item is the result
// synchronous active-low reset loads the clock with 2020-02-28 23:59:50.15, stopwatch off
// a stalled result holds the state; the input register still takes one more item,
// then in_stall rises until the result transfers
module calendar_clock_with_stopwatch (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [11:0] in_set_year,
  input  logic [3:0]  in_set_month,
  input  logic [4:0]  in_set_day,
  input  logic [4:0]  in_set_hour,
  input  logic [5:0]  in_set_minute,
  input  logic [5:0]  in_set_second,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second,
  output logic [6:0]  out_centisecond,
  output logic        out_chrono_running,
  output logic [31:0] out_chrono_seconds
);
  import ccws_pkg::*;

  ccws_item_t  item_r;
  logic        item_vld_r;
  ccws_state_t st_r;
  ccws_state_t st_nxt;
  logic        out_vld_r;
  logic        advance;

  // the held item moves into the state when the result slot is free or draining
  assign advance  = item_vld_r && !(out_vld_r && out_stall);
  assign in_stall = item_vld_r && out_vld_r && out_stall;

  // input register: loads on every transfer, keeps its item while blocked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (!in_stall) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r.func       <= func_t'(in_func);
      item_r.set_year   <= in_set_year;
      item_r.set_month  <= in_set_month;
      item_r.set_day    <= in_set_day;
      item_r.set_hour   <= in_set_hour;
      item_r.set_minute <= in_set_minute;
      item_r.set_second <= in_set_second;
    end
  end

  // calendar cascade and command decode
  ccws_step u_step (
    .item (item_r),
    .cur  (st_r),
    .nxt  (st_nxt)
  );

  // clock state, doubling as the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.year         <= RST_YEAR;
      st_r.month        <= RST_MONTH;
      st_r.day          <= RST_DAY;
      st_r.hour         <= RST_HOUR;
      st_r.minute       <= RST_MINUTE;
      st_r.second       <= RST_SECOND;
      st_r.centi        <= RST_CENTI;
      st_r.chrono_on    <= 1'b0;
      st_r.chrono_total <= 32'd0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // result valid: set by each applied item, cleared once the result transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_year           = st_r.year;
  assign out_month          = st_r.month;
  assign out_day            = st_r.day;
  assign out_hour           = st_r.hour;
  assign out_minute         = st_r.minute;
  assign out_second         = st_r.second;
  assign out_centisecond    = st_r.centi;
  assign out_chrono_running = st_r.chrono_on;
  assign out_chrono_seconds = st_r.chrono_total;

endmodule

// File: sim/tb_top.sv
// testbench for calendar_clock_with_stopwatch: directed and random command streams,
// a calendar predictor in a small class, and field-by-field checking of every result
// depends on ccws_pkg and the calendar_clock_with_stopwatch rtl
module tb_top;
  import ccws_pkg::*;

  // cycles with no transfer on either side before the run is called hung
  localparam int unsigned QUIET_LIMIT = 2000;
  // commands offered in total, directed part included; the last run may go a little past
  localparam int unsigned ITEM_TARGET = 820;
  // last stretch of the run goes without any idling
  localparam int unsigned TAIL_ITEMS  = 80;
  // long receiver hold-off, started once after this many results
  localparam int unsigned HOLD_AFTER  = 250;
  localparam int unsigned HOLD_CYCLES = 60;

  // predictor of the clock state plus the queue of expected results
  class calendar_checker;
    int unsigned yr, mon, dy, hr, mi, se, cs;
    bit          running;
    bit [31:0]   lap_secs;
    ccws_state_t expected_times[$];
    int unsigned mismatches, checked, month_ends, year_ends;

    function new();
      yr         = RST_YEAR;
      mon        = RST_MONTH;
      dy         = RST_DAY;
      hr         = RST_HOUR;
      mi         = RST_MINUTE;
      se         = RST_SECOND;
      cs         = RST_CENTI;
      running    = 1'b0;
      lap_secs   = '0;
      mismatches = 0;
      checked    = 0;
      month_ends = 0;
      year_ends  = 0;
    endfunction

    // months outside 1..12 are treated as 31 days long
    static function int unsigned month_length(int unsigned m, int unsigned y);
      case (m)
        2:             return (y % 4 == 0) ? 29 : 28;
        4, 6, 9, 11:   return 30;
        default:       return 31;
      endcase
    endfunction

    // one 10 ms step; each carry check runs once, month length taken before the step
    function void advance_tick();
      int unsigned limit;
      limit = month_length(mon, yr);
      cs++;
      if (cs >= 100) begin
        cs = 0;
        se++;
        if (running) lap_secs++;
      end
      if (se >= 60) begin
        se = 0;
        mi++;
      end
      if (mi >= 60) begin
        mi = 0;
        hr++;
      end
      if (hr >= 24) begin
        hr = 0;
        dy++;
      end
      if (dy > limit) begin
        dy = 1;
        mon++;
        month_ends++;
      end
      if (mon > 12) begin
        mon = 1;
        yr  = (yr + 1) & 12'hfff;
        year_ends++;
      end
    endfunction

    function void note_input(ccws_item_t it);
      ccws_state_t r;
      case (it.func)
        FUNC_TICK: advance_tick();
        FUNC_SET: begin
          yr  = it.set_year;
          mon = it.set_month;
          dy  = it.set_day;
          hr  = it.set_hour;
          mi  = it.set_minute;
          se  = it.set_second;
          cs  = 0;
        end
        FUNC_START: begin
          running  = 1'b1;
          lap_secs = '0;
        end
        default: begin
          running  = 1'b0;
          lap_secs = '0;
        end
      endcase
      r.year         = yr[11:0];
      r.month        = mon[3:0];
      r.day          = dy[4:0];
      r.hour         = hr[4:0];
      r.minute       = mi[5:0];
      r.second       = se[5:0];
      r.centi        = cs[6:0];
      r.chrono_on    = running;
      r.chrono_total = lap_secs;
      expected_times.push_back(r);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %0d at %0t:%s", mismatches, $realtime, what);
    endfunction

    function void check_result(ccws_state_t got);
      ccws_state_t want;
      string       diff;
      if (expected_times.size() == 0) begin
        flag(" result transfer with nothing expected");
        return;
      end
      want = expected_times.pop_front();
      checked++;
      diff = "";
      if (got.year != want.year)
        diff = {diff, $sformatf(" year exp %0d got %0d", want.year, got.year)};
      if (got.month != want.month)
        diff = {diff, $sformatf(" month exp %0d got %0d", want.month, got.month)};
      if (got.day != want.day)
        diff = {diff, $sformatf(" day exp %0d got %0d", want.day, got.day)};
      if (got.hour != want.hour)
        diff = {diff, $sformatf(" hour exp %0d got %0d", want.hour, got.hour)};
      if (got.minute != want.minute)
        diff = {diff, $sformatf(" minute exp %0d got %0d", want.minute, got.minute)};
      if (got.second != want.second)
        diff = {diff, $sformatf(" second exp %0d got %0d", want.second, got.second)};
      if (got.centi != want.centi)
        diff = {diff, $sformatf(" centisecond exp %0d got %0d", want.centi, got.centi)};
      if (got.chrono_on !== want.chrono_on)
        diff = {diff, $sformatf(" running exp %0b got %0b", want.chrono_on, got.chrono_on)};
      if (got.chrono_total !== want.chrono_total)
        diff = {diff, $sformatf(" stopwatch exp %0d got %0d",
                                want.chrono_total, got.chrono_total)};
      if (diff != "") flag(diff);
    endfunction

    function int unsigned pending();
      return expected_times.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [11:0] in_set_year;
  logic [3:0]  in_set_month;
  logic [4:0]  in_set_day;
  logic [4:0]  in_set_hour;
  logic [5:0]  in_set_minute;
  logic [5:0]  in_set_second;
  logic        out_valid;
  logic        out_stall;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [6:0]  out_centisecond;
  logic        out_chrono_running;
  logic [31:0] out_chrono_seconds;

  calendar_checker book;
  int unsigned     items_sent;
  int unsigned     results_seen;
  int unsigned     gap_pct;      // sender idle chance per transfer, changes per sequence
  bit              tail_quiet;   // set near the end: no idling on either side
  int unsigned     quiet_cycles;

  calendar_clock_with_stopwatch i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- stimulus helpers

  // any command with random filler in the set fields, so every bit toggles
  function automatic ccws_item_t command(func_t f);
    ccws_item_t it;
    it.func       = f;
    it.set_year   = 12'($urandom_range(0, 4095));
    it.set_month  = 4'($urandom_range(0, 15));
    it.set_day    = 5'($urandom_range(0, 31));
    it.set_hour   = 5'($urandom_range(0, 31));
    it.set_minute = 6'($urandom_range(0, 63));
    it.set_second = 6'($urandom_range(0, 63));
    return it;
  endfunction

  function automatic ccws_item_t make_set(int unsigned y, int unsigned mo, int unsigned d,
                                          int unsigned h, int unsigned mi, int unsigned s);
    ccws_item_t it;
    it.func       = FUNC_SET;
    it.set_year   = y[11:0];
    it.set_month  = mo[3:0];
    it.set_day    = d[4:0];
    it.set_hour   = h[4:0];
    it.set_minute = mi[5:0];
    it.set_second = s[5:0];
    return it;
  endfunction

  // legal date and time, mostly parked just before a minute, day, month or year end
  function automatic ccws_item_t boundary_set();
    int unsigned y, mo, d, h, mi, s;
    case ($urandom_range(0, 3))
      0:       y = 4095;
      1:       y = $urandom_range(0, 1023) * 4;
      2:       y = $urandom_range(0, 4095);
      default: y = 2020 + $urandom_range(0, 8);
    endcase
    mo = ($urandom_range(0, 3) == 0) ? 12 : $urandom_range(1, 12);
    d  = ($urandom_range(0, 9) < 6) ? calendar_checker::month_length(mo, y)
                                    : $urandom_range(1, calendar_checker::month_length(mo, y));
    h  = ($urandom_range(0, 9) < 7) ? 23 : $urandom_range(0, 23);
    mi = ($urandom_range(0, 9) < 7) ? 59 : $urandom_range(0, 59);
    s  = ($urandom_range(0, 9) < 8) ? 59 : $urandom_range(0, 59);
    return make_set(y, mo, d, h, mi, s);
  endfunction

  // offer one command, hold it until the block takes it, then maybe go idle for a burst
  task automatic offer(input ccws_item_t it);
    in_valid      <= 1'b1;
    in_func       <= it.func;
    in_set_year   <= it.set_year;
    in_set_month  <= it.set_month;
    in_set_day    <= it.set_day;
    in_set_hour   <= it.set_hour;
    in_set_minute <= it.set_minute;
    in_set_second <= it.set_second;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_input(it);
    items_sent++;
    if (items_sent >= ITEM_TARGET - TAIL_ITEMS) tail_quiet = 1'b1;
    if (!tail_quiet && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // well-formed run: load a time, maybe start the stopwatch, then tick, mostly across a carry
  task automatic calendar_run();
    int unsigned n_ticks;
    offer(boundary_set());
    if ($urandom_range(0, 1) == 1) offer(command(FUNC_START));
    n_ticks = ($urandom_range(0, 3) != 0) ? $urandom_range(100, 112) : $urandom_range(1, 40);
    repeat (n_ticks) begin
      if ($urandom_range(0, 99) < 2)
        offer(command(($urandom_range(0, 1) == 1) ? FUNC_START : FUNC_STOP));
      else
        offer(command(FUNC_TICK));
    end
  endtask

  // noise: any command with any field values, out-of-range sets included
  task automatic noise_burst();
    int unsigned pick;
    repeat ($urandom_range(5, 25)) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      offer(command(FUNC_TICK));
      else if (pick < 70) offer(command(FUNC_SET));
      else if (pick < 85) offer(command(FUNC_START));
      else                offer(command(FUNC_STOP));
    end
  endtask

  // ---------------------------------------------------------------- main sequence

  initial begin
    book          = new();
    items_sent    = 0;
    tail_quiet    = 1'b0;
    gap_pct       = 0;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_func       <= FUNC_TICK;
    in_set_year   <= '0;
    in_set_month  <= '0;
    in_set_day    <= '0;
    in_set_hour   <= '0;
    in_set_minute <= '0;
    in_set_second <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset state, stopwatch commands, all-ones fields wrapping every counter but centi
    // at once (year 4095 to 0), month zero, leap and common february, year end
    gap_pct = 10;
    offer(command(FUNC_TICK));
    offer(command(FUNC_START));
    offer(command(FUNC_TICK));
    offer(make_set(4095, 15, 31, 31, 63, 63));
    offer(command(FUNC_TICK));
    offer(make_set(0, 0, 0, 0, 0, 0));
    offer(command(FUNC_TICK));
    offer(make_set(0, 0, 31, 23, 59, 60));    // month zero moves on to january
    offer(command(FUNC_TICK));
    offer(make_set(2024, 2, 29, 23, 59, 60)); // leap february end
    offer(command(FUNC_TICK));
    offer(make_set(2023, 2, 28, 23, 59, 60)); // common february end
    offer(command(FUNC_TICK));
    offer(make_set(2023, 2, 29, 0, 0, 0));    // day past month end fixed on next tick
    offer(command(FUNC_TICK));
    offer(make_set(2024, 12, 31, 23, 59, 60));
    offer(command(FUNC_TICK));
    offer(command(FUNC_STOP));
    offer(command(FUNC_START));
    offer(command(FUNC_STOP));
    offer(make_set(4095, 12, 31, 23, 59, 59));
    offer(command(FUNC_TICK));

    // random: mostly well-formed runs across carries, the rest noise
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 4;
        default: gap_pct = 15;
      endcase
      if ($urandom_range(0, 99) < 70) calendar_run();
      else                            noise_burst();
    end
    in_valid <= 1'b0;

    // drain, then keep watching to catch any stray result transfer
    while (book.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run: %0d command transfers, %0d results checked", items_sent, book.checked);
    $display("run: %0d month ends and %0d year ends crossed", book.month_ends,
             book.year_ends);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // ---------------------------------------------------------------- result side

  // checks each result transfer and drives out_stall: random bursts, one long hold-off
  // that fills the block and pushes back on the input, nothing in the tail
  initial begin : result_side
    ccws_state_t got;
    bit          next_stall;
    int unsigned burst_left;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned stall_pct;
    int unsigned cycle_count;
    out_stall    <= 1'b0;
    burst_left   = 0;
    hold_left    = 0;
    hold_done    = 1'b0;
    stall_pct    = 0;
    cycle_count  = 0;
    results_seen = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        got.year         = out_year;
        got.month        = out_month;
        got.day          = out_day;
        got.hour         = out_hour;
        got.minute       = out_minute;
        got.second       = out_second;
        got.centi        = out_centisecond;
        got.chrono_on    = out_chrono_running;
        got.chrono_total = out_chrono_seconds;
        book.check_result(got);
        results_seen++;
      end
      // stall density changes now and then, zero included
      cycle_count++;
      if (cycle_count % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 5;
          default: stall_pct = 20;
        endcase
      end
      if (hold_left > 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done  = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        next_stall = 1'b1;
      end else if (tail_quiet) begin
        next_stall = 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        next_stall = 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        burst_left = $urandom_range(0, 13);
        next_stall = 1'b1;
      end else begin
        next_stall = 1'b0;
      end
      out_stall <= next_stall;
    end
  end

  // ---------------------------------------------------------------- watchdog

  // ends the run when no transfer happens on either side for too long
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
